>>> hdl/hclp_pkg.sv
// Package for the color-list line parser: item and result types, keyword constants.
// Used by hclp_core, hclp_out_fifo and hex_color_list_line_parser_top.
`timescale 1ns / 1ps
`default_nettype none

package hclp_pkg;

    // One input item: a byte of the line and the end-of-line mark.
    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_item;

    // One result item: a slot or the end-of-line summary.
    typedef struct packed {
        logic        kind;
        logic [4:0]  slot_index;
        logic        color_valid;
        logic [3:0]  digit_count;
        logic [31:0] color_value;
        logic        palette_found;
        logic        final_result;
    } t_result;

    // Up to two results produced by one byte, with their count.
    typedef struct packed {
        t_result    res0;
        t_result    res1;
        logic [1:0] num;
    } t_emit;

    // Result kinds.
    localparam logic KIND_SLOT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Parser phases.
    localparam logic [1:0] PH_KEY   = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;

    // Key window holds the last 15 lowercased key bytes, newest in the low byte.
    // The keywords are lowercase ASCII, first character in the high byte: the tool
    // and the spool color keys, each in the long and the short spelling.
    localparam int KEY_LEN = 15;
    localparam logic [119:0] KW_TOOL_LONG   = 120'h6578747275646572_5F636F6C6F7572;
    localparam logic [111:0] KW_TOOL_SHORT  = 112'h6578747275646572_5F636F6C6F72;
    localparam logic [119:0] KW_SPOOL_LONG  = 120'h66696C616D656E74_5F636F6C6F7572;
    localparam logic [111:0] KW_SPOOL_SHORT = 112'h66696C616D656E74_5F636F6C6F72;

endpackage

`default_nettype wire

>>> hdl/hclp_core.sv
// Parser state and per-byte update logic; produces up to two results per byte.
// Depends on hclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hclp_core #(
    parameter int MAX_SLOTS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_fire,
    input  hclp_pkg::t_item  i_item,
    output hclp_pkg::t_emit  o_emit
);

    // Slot counter is at least 5 bits so the index output is a plain part-select.
    localparam int CntRaw = $clog2(MAX_SLOTS + 1);
    localparam int CntW   = (CntRaw > 5) ? CntRaw : 5;
    localparam int WinW   = hclp_pkg::KEY_LEN * 8;

    // Character codes.
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;

    logic [1:0]      r_phase,      n_phase;
    logic [WinW-1:0] r_window,     n_window;
    logic            r_kw,         n_kw;
    logic            r_started,    n_started;
    logic            r_hash,       n_hash;
    logic            r_pend,       n_pend;
    logic [3:0]      r_len,        n_len;
    logic            r_allhex,     n_allhex;
    logic [31:0]     r_acc,        n_acc;
    logic [CntW-1:0] r_slot_cnt,   n_slot_cnt;
    logic            r_any_valid,  n_any_valid;

    logic [7:0]      c;
    logic            last;
    logic            is_sep;
    logic            is_trim;
    logic            is_hex;
    logic [3:0]      hex_digit;
    logic [7:0]      lc;
    logic [WinW-1:0] win_shift;
    logic            kw_match;

    // Token state after taking a non-separator value byte.
    logic            u_started, u_hash, u_pend, u_allhex;
    logic [3:0]      u_len, len_a;
    logic [31:0]     u_acc;

    // Token that is being closed.
    logic            e_started, e_hash, e_allhex;
    logic [3:0]      e_len;
    logic [31:0]     e_acc;
    logic            emit_req, slot_ok, col_ok;
    logic [CntW-1:0] cnt_after;
    logic            any_after;
    hclp_pkg::t_result slot_res, sum_res;

    function automatic logic [3:0] sat_inc(input logic [3:0] v);
        sat_inc = (v == 4'd15) ? v : v + 4'd1;
    endfunction

    assign c    = i_item.char_code;
    assign last = i_item.line_end;

    // Character classes.
    always_comb begin
        is_sep  = (c == CH_SEMI) || (c == CH_COMMA);
        is_trim = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
                  (c == CH_DQ) || (c == CH_SQ);
        is_hex    = 1'b1;
        hex_digit = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_digit = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_digit = c[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    end

    // Keyword window: shift in the lowercased byte and compare its tail.
    assign win_shift = {r_window[WinW-9:0], lc};
    assign kw_match  = (win_shift == hclp_pkg::KW_TOOL_LONG) ||
                       (win_shift[111:0] == hclp_pkg::KW_TOOL_SHORT) ||
                       (win_shift == hclp_pkg::KW_SPOOL_LONG) ||
                       (win_shift[111:0] == hclp_pkg::KW_SPOOL_SHORT);

    // Token update for a value byte that is not a separator.
    always_comb begin
        u_started = r_started;
        u_hash    = r_hash;
        u_pend    = r_pend;
        u_len     = r_len;
        u_allhex  = r_allhex;
        u_acc     = r_acc;
        len_a     = r_pend ? sat_inc(r_len) : r_len;
        if (is_trim) begin
            if (r_started) begin
                u_pend = 1'b1;
            end
        end else if (!r_started) begin
            u_started = 1'b1;
            u_hash    = (c == CH_HASH);
        end else begin
            // A trim character inside the token counts as a body byte and spoils it.
            u_pend   = 1'b0;
            u_len    = sat_inc(len_a);
            u_allhex = r_allhex && !r_pend && is_hex;
            if (is_hex) begin
                u_acc = {r_acc[27:0], hex_digit};
            end
        end
    end

    // Slot emission: at a separator the current token closes, at line end the updated one.
    always_comb begin
        e_started = is_sep ? r_started : u_started;
        e_hash    = is_sep ? r_hash    : u_hash;
        e_allhex  = is_sep ? r_allhex  : u_allhex;
        e_len     = is_sep ? r_len     : u_len;
        e_acc     = is_sep ? r_acc     : u_acc;
        emit_req  = (r_phase == hclp_pkg::PH_VALUE) && (is_sep || (last && u_started));
        slot_ok   = emit_req && (r_slot_cnt < CntW'(MAX_SLOTS));
        col_ok    = e_started && e_hash && e_allhex && ((e_len == 4'd6) || (e_len == 4'd8));
        cnt_after = slot_ok ? r_slot_cnt + CntW'(1) : r_slot_cnt;
        any_after = r_any_valid || (slot_ok && col_ok);
    end

    // Phase after this byte, before any end-of-line reset.
    always_comb begin
        n_phase = r_phase;
        if (r_phase == hclp_pkg::PH_KEY && c == CH_EQ) begin
            n_phase = r_kw ? hclp_pkg::PH_VALUE : hclp_pkg::PH_SKIP;
        end
    end

    // Result items.
    always_comb begin
        slot_res.kind          = hclp_pkg::KIND_SLOT;
        slot_res.slot_index    = r_slot_cnt[4:0];
        slot_res.color_valid   = col_ok;
        slot_res.digit_count   = col_ok ? e_len : 4'd0;
        slot_res.color_value   = col_ok ? e_acc : 32'd0;
        slot_res.palette_found = 1'b0;
        slot_res.final_result  = !last;

        sum_res.kind          = hclp_pkg::KIND_SUMMARY;
        sum_res.slot_index    = cnt_after[4:0];
        sum_res.color_valid   = 1'b0;
        sum_res.digit_count   = 4'd0;
        sum_res.color_value   = 32'd0;
        sum_res.palette_found = (n_phase == hclp_pkg::PH_VALUE) && any_after;
        sum_res.final_result  = 1'b1;

        o_emit.res0 = slot_ok ? slot_res : sum_res;
        o_emit.res1 = sum_res;
        o_emit.num  = {1'b0, slot_ok} + {1'b0, last};
    end

    // Next state.
    always_comb begin
        n_window    = r_window;
        n_kw        = r_kw;
        n_started   = r_started;
        n_hash      = r_hash;
        n_pend      = r_pend;
        n_len       = r_len;
        n_allhex    = r_allhex;
        n_acc       = r_acc;
        n_slot_cnt  = cnt_after;
        n_any_valid = any_after;
        if (r_phase == hclp_pkg::PH_KEY && c != CH_EQ) begin
            n_window = win_shift;
            n_kw     = r_kw || kw_match;
        end
        if (r_phase == hclp_pkg::PH_VALUE) begin
            if (emit_req) begin
                n_started = 1'b0;
                n_hash    = 1'b0;
                n_pend    = 1'b0;
                n_len     = 4'd0;
                n_allhex  = 1'b1;
                n_acc     = 32'd0;
            end else begin
                n_started = u_started;
                n_hash    = u_hash;
                n_pend    = u_pend;
                n_len     = u_len;
                n_allhex  = u_allhex;
                n_acc     = u_acc;
            end
        end
    end

    // State registers; the end of a line returns everything to its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && last)) begin
            r_phase     <= hclp_pkg::PH_KEY;
            r_window    <= '0;
            r_kw        <= 1'b0;
            r_started   <= 1'b0;
            r_hash      <= 1'b0;
            r_pend      <= 1'b0;
            r_len       <= 4'd0;
            r_allhex    <= 1'b1;
            r_acc       <= 32'd0;
            r_slot_cnt  <= '0;
            r_any_valid <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_window    <= n_window;
            r_kw        <= n_kw;
            r_started   <= n_started;
            r_hash      <= n_hash;
            r_pend      <= n_pend;
            r_len       <= n_len;
            r_allhex    <= n_allhex;
            r_acc       <= n_acc;
            r_slot_cnt  <= n_slot_cnt;
            r_any_valid <= n_any_valid;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hclp_out_fifo.sv
// Four-entry result queue: takes up to two results per cycle, gives one while i_ready is high.
// Depends on hclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hclp_out_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_wr_en,
    input  hclp_pkg::t_emit    i_emit,
    output logic               o_room2,
    output logic               o_valid,
    output hclp_pkg::t_result  o_data,
    input  wire                i_ready
);

    hclp_pkg::t_result r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count,  n_count;
    logic [1:0] wr_num;
    logic       rd_en;

    assign wr_num  = i_wr_en ? i_emit.num : 2'd0;
    assign rd_en   = o_valid && i_ready;
    assign o_valid = (r_count != 3'd0);
    assign o_room2 = (r_count <= 3'd2);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill-count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + wr_num;
        n_rd_ptr = r_rd_ptr + {1'b0, rd_en};
        n_count  = r_count + {1'b0, wr_num} - {2'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage writes: the first result, then the second one behind it.
    always_ff @(posedge i_clk) begin
        if (wr_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.res0;
        end
        if (wr_num == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_emit.res1;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hex_color_list_line_parser_top.sv
// Top level of the color-list line parser: input register, parser core, result queue.
// Depends on hclp_pkg, hclp_core and hclp_out_fifo.
//
// Usage: bytes of one text line enter on the input channel (i_in_valid, o_in_ready,
// i_in_item), line_end set on the last byte. Results leave on the output channel
// (o_out_valid, i_out_ready, o_out_item): one slot item per token after the first '='
// of a line whose key holds a color keyword, up to MAX_SLOTS of them, then one summary
// item at every line end. final_result marks the last result caused by a given byte.
// An accepted byte waits in the input register until the queue has room for two
// results; its results are then written into a four-entry queue, which drives the
// output channel.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver takes every result offered. A byte that causes two (separator or token end
// together with line end) needs two output transfers; the queue absorbs that, and the
// input register waits while fewer than two queue entries are free.
// Reset clears the parser state, the input register and the queue. When the receiver
// stalls, the queue fills, the input register holds its byte, and o_in_ready falls.
`timescale 1ns / 1ps
`default_nettype none

module hex_color_list_line_parser_top #(
    parameter int MAX_SLOTS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  hclp_pkg::t_item    i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output hclp_pkg::t_result  o_out_item
);

    logic              r_in_valid;
    hclp_pkg::t_item   r_in_item;
    logic              fire;
    logic              room2;
    hclp_pkg::t_emit   emit;

    // The held byte is processed when the queue has room for both possible results.
    assign fire       = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    hclp_core #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_emit  (emit)
    );

    hclp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (fire),
        .i_emit  (emit),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .o_data  (o_out_item),
        .i_ready (i_out_ready)
    );

endmodule

`default_nettype wire
